// ===== hw/rtl/polygon_point_containment_assert.svh =====
// Assertion macros shared by the polygon containment RTL.
// Each macro expects clk and rst (synchronous, active high) in the calling scope.
`ifndef POLYGON_POINT_CONTAINMENT_ASSERT_SVH
`define POLYGON_POINT_CONTAINMENT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ppc_pkg.sv =====
// Shared sizes, codes and control structs for the polygon containment block.
// No dependencies; the interfaces, the RTL modules and the testbench import this package.
package ppc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_TEST  = 2'd3
  } ppc_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_FINISH
  } ppc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic  take;       // request beat accepted this cycle
    logic  rd_en;      // read one vertex from the store
    addr_t rd_addr;
    logic  rd_edge;    // read closes an edge with the previous vertex
    logic  load_test;  // load the crossing parity into the response register
  } ppc_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic   walk_req;  // pending request is a test on a non-empty store
    logic   out_valid;
    logic   out_busy;  // response held and not taken this cycle
    count_t count;
  } ppc_sts_t;

endpackage

// ===== hw/rtl/ppc_in_if.sv =====
// Request channel: valid/ready handshake with action and point payload.
// Depends on ppc_pkg.
interface ppc_in_if;
  import ppc_pkg::*;

  logic        valid;
  logic        ready;
  ppc_action_t action;
  coord_t      point_x;
  coord_t      point_y;

  modport source (output valid, action, point_x, point_y, input ready);
  modport sink   (input valid, action, point_x, point_y, output ready);
endinterface

// ===== hw/rtl/ppc_out_if.sv =====
// Response channel: valid/ready handshake with containment result payload.
// Depends on ppc_pkg.
interface ppc_out_if;
  import ppc_pkg::*;

  logic   valid;
  logic   ready;
  logic   inside_res;
  count_t vertex_count;
  logic   status;

  modport source (output valid, inside_res, vertex_count, status, input ready);
  modport sink   (input valid, inside_res, vertex_count, status, output ready);
endinterface

// ===== hw/rtl/ppc_ctrl.sv =====
// Sequencer for the polygon containment block: accepts requests and walks the
// vertex store for point tests. Depends on ppc_pkg and the assertion header.
`include "polygon_point_containment_assert.svh"

module ppc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ppc_pkg::ppc_sts_t sts,
  output ppc_pkg::ppc_ctl_t ctl
);
  import ppc_pkg::*;

  ppc_state_t state, state_next;
  count_t     idx, idx_next;
  count_t     count_m1;

  assign count_m1 = sts.count - COUNT_W'(1);

  // State and walk index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    req_ready     = 1'b0;
    ctl           = '0;
    case (state)
      ST_IDLE: begin
        req_ready = !sts.out_busy;
        ctl.take  = req_valid && !sts.out_busy;
        if (ctl.take && sts.walk_req) begin
          state_next = ST_PRIME;
        end
      end
      // Fetch the last vertex so the first edge closes the polygon
      ST_PRIME: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = count_m1[ADDR_W-1:0];
        ctl.rd_edge = 1'b0;
        idx_next    = '0;
        state_next  = ST_WALK;
      end
      // Advance one vertex per cycle, each read closing one edge
      ST_WALK: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = idx[ADDR_W-1:0];
        ctl.rd_edge = 1'b1;
        idx_next    = idx + COUNT_W'(1);
        if (idx == count_m1) begin
          state_next = ST_DRAIN_A;
        end
      end
      // Let the read, product and parity stages empty
      ST_DRAIN_A: state_next = ST_DRAIN_B;
      ST_DRAIN_B: state_next = ST_FINISH;
      ST_FINISH: begin
        ctl.load_test = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `PPC_ASSERT_NOW(a_rd_in_range, ctl.rd_en, COUNT_W'(ctl.rd_addr) < sts.count, "read beyond stored vertices")
  `PPC_ASSERT_NOW(a_prime_last, ctl.rd_en && !ctl.rd_edge, ctl.rd_addr == count_m1[ADDR_W-1:0], "walk does not start at last vertex")
  `PPC_ASSERT_NOW(a_finish_free, ctl.load_test, !sts.out_valid, "test result overwrites pending beat")

endmodule

// ===== hw/rtl/ppc_datapath.sv =====
// Vertex store, edge crossing pipeline and response register of the polygon
// containment block. Depends on ppc_pkg and the assertion header.
`include "polygon_point_containment_assert.svh"

module ppc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ppc_pkg::ppc_action_t req_action,
  input  ppc_pkg::coord_t      req_x,
  input  ppc_pkg::coord_t      req_y,
  input  logic                 rsp_ready,
  output logic                 rsp_valid,
  output logic                 rsp_inside,
  output ppc_pkg::count_t      rsp_count,
  output logic                 rsp_status,
  input  ppc_pkg::ppc_ctl_t    ctl,
  output ppc_pkg::ppc_sts_t    sts
);
  import ppc_pkg::*;

  // Vertex store, {x, y} per entry
  logic [2*COORD_WIDTH-1:0] vstore [MAX_VERTICES];

  count_t count, count_next;
  logic   full, refused, wr_en;

  coord_t px, py;
  coord_t rd_x, rd_y, prev_x, prev_y;
  logic   rd_valid, rd_edge;

  logic                     e_valid, e_cross, e_dy_pos;
  logic signed [PROD_W-1:0] e_lhs, e_rhs;
  logic                     parity, hit;

  logic signed [DIFF_W-1:0] d_px, d_py, d_xj, d_dy;
  logic                     above_i, above_j;

  assign full = (count == COUNT_W'(MAX_VERTICES));

  // Decode the request into store and count updates
  always_comb begin
    count_next = count;
    refused    = 1'b0;
    wr_en      = 1'b0;
    case (req_action)
      ACT_PUSH: begin
        if (full) begin
          refused = 1'b1;
        end else begin
          wr_en      = ctl.take;
          count_next = count + COUNT_W'(1);
        end
      end
      ACT_POP: begin
        if (count != '0) begin
          count_next = count - COUNT_W'(1);
        end
      end
      ACT_CLEAR: count_next = '0;
      ACT_TEST:  count_next = count;
      default:   count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.take) begin
      count <= count_next;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vstore[count[ADDR_W-1:0]] <= {req_x, req_y};
    end
    if (ctl.rd_en) begin
      {rd_x, rd_y} <= vstore[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_edge  <= 1'b0;
    end else begin
      rd_valid <= ctl.rd_en;
      rd_edge  <= ctl.rd_edge;
    end
  end

  // Hold the test point for the whole walk
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      px <= req_x;
      py <= req_y;
    end
  end

  // Edge stage: vertex i is the fresh read, vertex j the one before it
  assign above_i = rd_y > py;
  assign above_j = prev_y > py;
  assign d_px    = DIFF_W'(px) - DIFF_W'(rd_x);
  assign d_py    = DIFF_W'(py) - DIFF_W'(rd_y);
  assign d_xj    = DIFF_W'(prev_x) - DIFF_W'(rd_x);
  assign d_dy    = DIFF_W'(prev_y) - DIFF_W'(rd_y);

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    e_cross  <= above_i != above_j;
    e_dy_pos <= prev_y > rd_y;
    e_lhs    <= d_px * d_dy;
    e_rhs    <= d_xj * d_py;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= rd_valid && rd_edge;
    end
  end

  // Parity stage: toggle on each crossing right of the point
  assign hit = e_dy_pos ? (e_lhs < e_rhs) : (e_rhs < e_lhs);

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      parity <= 1'b0;
    end else if (e_valid && e_cross && hit) begin
      parity <= !parity;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_test || (ctl.take && !sts.walk_req)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_test) begin
      rsp_inside <= parity;
      rsp_count  <= count;
      rsp_status <= 1'b0;
    end else if (ctl.take && !sts.walk_req) begin
      rsp_inside <= 1'b0;
      rsp_count  <= count_next;
      rsp_status <= refused;
    end
  end

  assign sts.walk_req  = (req_action == ACT_TEST) && (count != '0);
  assign sts.out_valid = rsp_valid;
  assign sts.out_busy  = rsp_valid && !rsp_ready;
  assign sts.count     = count;

  `PPC_ASSERT_NOW(a_count_max, 1'b1, count <= COUNT_W'(MAX_VERTICES), "vertex count above capacity")
  `PPC_ASSERT_NOW(a_refuse_full, rsp_valid && rsp_status, rsp_count == COUNT_W'(MAX_VERTICES), "push refused while store not full")
  `PPC_ASSERT_NOW(a_inside_edges, rsp_valid && rsp_inside, rsp_count >= COUNT_W'(2), "inside reported without a crossable edge")

endmodule

// ===== hw/rtl/polygon_point_containment.sv =====
// Top level of the polygon containment block: joins the sequencer and the
// datapath to the request and response channels. Depends on ppc_pkg, ppc_in_if,
// ppc_out_if, ppc_ctrl and ppc_datapath.
//
// Keeps up to 64 polygon vertices (signed Q12.4) and answers one response beat
// per request beat. Push, pop and clear are handled without leaving the idle
// state. A point test reads the vertex store one entry per cycle through its
// single read port, closing one edge per read, and passes through the prime,
// walk, drain and finish states before the next request can be taken; a test
// on an empty store is answered without a walk. A finished response waits in
// an output register; the next request is taken as soon as that register is
// free or being emptied. The test uses the even-odd crossing rule with exact
// 17 x 17 bit cross products, so no rounding is involved. A push to a full
// store is dropped and flagged in status.
module polygon_point_containment (
  input  logic      clk,
  input  logic      rst,
  ppc_in_if.sink    request,
  ppc_out_if.source response
);
  import ppc_pkg::*;

  ppc_ctl_t ctl;
  ppc_sts_t sts;

  ppc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ppc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req_action (request.action),
    .req_x      (request.point_x),
    .req_y      (request.point_y),
    .rsp_ready  (response.ready),
    .rsp_valid  (response.valid),
    .rsp_inside (response.inside_res),
    .rsp_count  (response.vertex_count),
    .rsp_status (response.status),
    .ctl        (ctl),
    .sts        (sts)
  );

endmodule

// ===== verif/tb_polygon_point_containment.sv =====
// Testbench for polygon_point_containment: directed table, then random polygons,
// checked against an even-odd crossing predictor. Depends on ppc_pkg,
// ppc_in_if, ppc_out_if and the block's RTL.
module tb_polygon_point_containment;
  import ppc_pkg::*;

  localparam coord_t COORD_MIN    = 16'sh8000;
  localparam coord_t COORD_MAX    = 16'sh7FFF;
  localparam int     RANDOM_ITEMS = 1130;
  localparam int     DRAIN_CYCLES = 80;
  localparam int     N_DIRECTED   = 20;

  typedef struct packed {
    logic   in_poly;
    count_t count;
    logic   status;
  } reply_t;

  typedef struct packed {
    ppc_action_t act;
    coord_t      x;
    coord_t      y;
    logic        typed;   // row carries its own expected reply
    reply_t      reply;
  } stim_row_t;

  localparam reply_t R_0_0 = '{1'b0, 7'd0, 1'b0};
  localparam reply_t R_0_1 = '{1'b0, 7'd1, 1'b0};
  localparam reply_t R_0_2 = '{1'b0, 7'd2, 1'b0};
  localparam reply_t R_0_3 = '{1'b0, 7'd3, 1'b0};
  localparam reply_t R_0_4 = '{1'b0, 7'd4, 1'b0};

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ACT_TEST,  16'sh0000, 16'sh0000, 1'b1, R_0_0},  // empty store
    '{ACT_TEST,  COORD_MAX, COORD_MIN, 1'b1, R_0_0},
    '{ACT_POP,   16'sh0000, 16'sh0000, 1'b1, R_0_0},  // pop on empty
    '{ACT_CLEAR, COORD_MIN, COORD_MAX, 1'b1, R_0_0},
    '{ACT_PUSH,  COORD_MIN, COORD_MIN, 1'b1, R_0_1},
    '{ACT_TEST,  COORD_MIN, COORD_MIN, 1'b1, R_0_1},  // single vertex
    '{ACT_PUSH,  COORD_MAX, COORD_MIN, 1'b1, R_0_2},
    '{ACT_TEST,  16'sh0000, 16'sh0000, 1'b0, R_0_0},
    '{ACT_TEST,  16'sh0000, COORD_MIN, 1'b0, R_0_0},
    '{ACT_PUSH,  COORD_MAX, COORD_MAX, 1'b1, R_0_3},
    '{ACT_PUSH,  COORD_MIN, COORD_MAX, 1'b1, R_0_4},
    '{ACT_TEST,  16'sh0000, 16'sh0000, 1'b0, R_0_0},
    '{ACT_TEST,  COORD_MAX, COORD_MAX, 1'b0, R_0_0},
    '{ACT_TEST,  COORD_MIN, 16'sh0000, 1'b0, R_0_0},
    '{ACT_TEST,  16'sh0010, 16'sh7FF0, 1'b0, R_0_0},
    '{ACT_POP,   16'sh5555, 16'shAAAA, 1'b1, R_0_3},
    '{ACT_TEST,  16'sh4000, 16'shC000, 1'b0, R_0_0},
    '{ACT_CLEAR, 16'sh0000, 16'sh0000, 1'b1, R_0_0},
    '{ACT_TEST,  16'sh0000, 16'sh0000, 1'b1, R_0_0},
    '{ACT_PUSH,  16'sh0123, 16'shFEDC, 1'b1, R_0_1}
  };

  logic clk = 1'b0;
  logic rst;

  ppc_in_if  req_ch ();
  ppc_out_if rsp_ch ();

  polygon_point_containment u_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch.sink),
    .response (rsp_ch.source)
  );

  // Predictor state: the polygon as the block should hold it
  coord_t poly_x [MAX_VERTICES];
  coord_t poly_y [MAX_VERTICES];
  int     poly_count;

  reply_t expected_replies [$];
  int     items_sent;
  int     src_idle_pct;
  int     snk_idle_pct;
  bit     failed;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Even-odd crossing count over every edge, exact in 64-bit integers
  function automatic logic point_inside(coord_t px_in, coord_t py_in);
    longint px, py, xi, yi, xj, yj, dy, lhs, rhs;
    int     i, j;
    logic   parity;
    parity = 1'b0;
    px = px_in;
    py = py_in;
    if (poly_count == 0) return 1'b0;
    j = poly_count - 1;
    for (i = 0; i < poly_count; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > py) != (yj > py)) begin
        dy  = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * (py - yi);
        if (dy > 0 ? (lhs < rhs) : (rhs < lhs)) parity = !parity;
      end
      j = i;
    end
    return parity;
  endfunction

  // Apply one request to the polygon copy and return the reply it causes
  function automatic reply_t apply_request(ppc_action_t act, coord_t x, coord_t y);
    reply_t r;
    r = '0;
    case (act)
      ACT_PUSH: begin
        if (poly_count < MAX_VERTICES) begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
        end else begin
          r.status = 1'b1;
        end
      end
      ACT_POP: begin
        if (poly_count > 0) poly_count--;
      end
      ACT_CLEAR: poly_count = 0;
      default:   r.in_poly = point_inside(x, y);
    endcase
    r.count = count_t'(poly_count);
    return r;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t near_coord(coord_t c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  // Drive one request beat and record the reply it should cause
  task automatic send_request(input ppc_action_t act, input coord_t x, input coord_t y,
                              input logic typed, input reply_t typed_reply);
    reply_t model_reply;
    if (items_sent < (N_DIRECTED + RANDOM_ITEMS) / 3) begin
      src_idle_pct = 35;
      snk_idle_pct = 56;
    end else if (items_sent < 2 * (N_DIRECTED + RANDOM_ITEMS) / 3) begin
      src_idle_pct = 56;
      snk_idle_pct = 35;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.point_x <= x;
    req_ch.point_y <= y;
    do @(posedge clk); while (!req_ch.ready);
    model_reply = apply_request(act, x, y);
    if (typed) model_reply = typed_reply;
    expected_replies = {expected_replies, model_reply};
    items_sent++;
  endtask

  task automatic send_noise();
    send_request(ppc_action_t'($urandom_range(3)), rand_coord(), rand_coord(), 1'b0, '0);
  endtask

  // Build one polygon with random content, then probe it
  task automatic run_shape(input bit fill_store);
    int     n_vert, n_test, k, idx, spread;
    coord_t cx, cy, tx, ty;
    case ($urandom_range(3))
      0:       spread = 16;
      1:       spread = 256;
      2:       spread = 4096;
      default: spread = 32767;
    endcase
    cx = rand_coord();
    cy = rand_coord();
    if ($urandom_range(99) < 80) send_request(ACT_CLEAR, rand_coord(), rand_coord(), 1'b0, '0);
    else repeat ($urandom_range(3)) send_request(ACT_POP, rand_coord(), rand_coord(), 1'b0, '0);

    if (fill_store)                  n_vert = MAX_VERTICES + $urandom_range(1, 3);
    else if ($urandom_range(9) == 0) n_vert = $urandom_range(2);
    else                             n_vert = $urandom_range(3, 12);
    for (k = 0; k < n_vert; k++) begin
      send_request(ACT_PUSH, near_coord(cx, spread), near_coord(cy, spread), 1'b0, '0);
      if ($urandom_range(99) < 6) send_noise();
    end

    n_test = $urandom_range(2, 8);
    for (k = 0; k < n_test; k++) begin
      idx = (poly_count > 0) ? $urandom_range(poly_count - 1) : 0;
      case ($urandom_range(4))
        0: begin  // exactly on a vertex
          tx = (poly_count > 0) ? poly_x[idx] : rand_coord();
          ty = (poly_count > 0) ? poly_y[idx] : rand_coord();
        end
        1: begin  // midpoint of an edge
          if (poly_count > 0) begin
            tx = coord_t'((longint'(poly_x[idx]) + poly_x[(idx + 1) % poly_count]) >>> 1);
            ty = coord_t'((longint'(poly_y[idx]) + poly_y[(idx + 1) % poly_count]) >>> 1);
          end else begin
            tx = rand_coord();
            ty = rand_coord();
          end
        end
        2: begin
          tx = near_coord(cx, spread);
          ty = near_coord(cy, spread);
        end
        3: begin
          tx = rand_coord();
          ty = rand_coord();
        end
        default: begin  // point at the height of a vertex
          tx = near_coord(cx, spread);
          ty = (poly_count > 0) ? poly_y[idx] : rand_coord();
        end
      endcase
      send_request(ACT_TEST, tx, ty, 1'b0, '0);
      if ($urandom_range(99) < 10) send_noise();
    end

    // Drop a vertex and probe again now and then
    if ($urandom_range(99) < 30) begin
      send_request(ACT_POP, rand_coord(), rand_coord(), 1'b0, '0);
      send_request(ACT_TEST, near_coord(cx, spread), near_coord(cy, spread), 1'b0, '0);
    end
  endtask

  // Compare each response beat with the oldest expected reply; randomize ready
  always @(posedge clk) begin : response_check
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: response beat with no reply pending (inside %0d count %0d status %0d)",
                 $time, rsp_ch.inside_res, rsp_ch.vertex_count, rsp_ch.status);
        failed = 1'b1;
      end else begin
        want = expected_replies.pop_front();
        if (rsp_ch.inside_res !== want.in_poly) begin
          $display("%0t: inside_res expected %0d actual %0d", $time, want.in_poly,
                   rsp_ch.inside_res);
          failed = 1'b1;
        end
        if (rsp_ch.vertex_count !== want.count) begin
          $display("%0t: vertex_count expected %0d actual %0d", $time, want.count,
                   rsp_ch.vertex_count);
          failed = 1'b1;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
          failed = 1'b1;
        end
      end
    end
    rsp_ch.ready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  // Main sequence: reset, directed table, random polygons, drain
  initial begin : stimulus
    int row, shape_idx;
    failed         = 1'b0;
    items_sent     = 0;
    poly_count     = 0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_PUSH;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    rsp_ch.ready   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < N_DIRECTED; row++)
      send_request(DIRECTED[row].act, DIRECTED[row].x, DIRECTED[row].y,
                   DIRECTED[row].typed, DIRECTED[row].reply);

    shape_idx = 0;
    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      run_shape(shape_idx % 10 == 9);
      shape_idx++;
    end
    req_ch.valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Stop a hung run
  initial begin
    #12000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_in_if.sv
hw/rtl/ppc_out_if.sv
hw/rtl/ppc_ctrl.sv
hw/rtl/ppc_datapath.sv
hw/rtl/polygon_point_containment.sv
verif/tb_polygon_point_containment.sv
